>>> sv/mpq_pkg.sv
// Package for the max priority queue: payload structs, operation and status codes,
// and the command and flag structs that join the controller and the datapath.
// No dependencies.
package mpq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 32;
  localparam int COUNT_W = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic                      operation;
    logic signed [VALUE_W-1:0] item_value;
    logic signed [PRIO_W-1:0]  item_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] removed_value;
    logic signed [PRIO_W-1:0]  removed_priority;
    logic [COUNT_W-1:0]        entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       insert;
    logic       walk_start;
    logic       walk_from_best;
    logic       scan;
    logic       shift;
    logic       pop;
    logic       report;
    logic [1:0] code;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op;
    logic empty;
    logic full;
    logic walk_done;
    logic rsp_free;
  } dp_flags_t;

endpackage

>>> sv/mpq_datapath.sv
// Datapath of the max priority queue: entry memory, occupancy, scan pointer,
// running maximum and the response register. Depends on mpq_pkg.
module mpq_datapath #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  mpq_pkg::req_t     req,
  input  mpq_pkg::dp_cmd_t  cmd,
  output mpq_pkg::dp_flags_t flags,
  input  logic              rsp_stall,
  output logic              rsp_valid,
  output mpq_pkg::rsp_t     rsp
);
  import mpq_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MEM_W  = PRIO_W + VALUE_W;

  // Each entry holds the priority in the upper half and the value in the lower half.
  logic [MEM_W-1:0] mem [DEPTH];

  req_t                      item;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [CNT_W-1:0]          ptr;
  logic                      rd_valid;
  logic [ADDR_W-1:0]         rd_idx;
  logic [MEM_W-1:0]          rdata;
  logic [ADDR_W-1:0]         best_idx;
  logic signed [PRIO_W-1:0]  best_prio;
  logic signed [VALUE_W-1:0] best_value;

  logic                      rd_issue;
  logic signed [PRIO_W-1:0]  rd_prio;
  logic                      take;
  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [MEM_W-1:0]          wdata;

  assign rd_issue = (cmd.scan || cmd.shift) && (ptr < count);
  assign rd_prio  = rdata[MEM_W-1:VALUE_W];
  // The first entry always seeds the maximum; later ones replace it only when strictly
  // greater, so the earliest of equal priorities is kept.
  assign take     = cmd.scan && rd_valid && ((rd_idx == '0) || (rd_prio > best_prio));

  assign we    = cmd.insert || (cmd.shift && rd_valid);
  assign waddr = cmd.insert ? count[ADDR_W-1:0] : (rd_idx - ADDR_W'(1));
  assign wdata = cmd.insert ? {item.item_priority, item.item_value} : rdata;

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    flags.op        = item.operation;
    flags.empty     = (count == '0);
    flags.full      = (count == CNT_W'(DEPTH));
    flags.walk_done = (ptr == count) && !rd_valid;
    flags.rsp_free  = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_issue) begin
      rdata <= mem[ptr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
    end
    if (rd_issue) begin
      rd_idx <= ptr[ADDR_W-1:0];
    end
    if (take) begin
      best_idx   <= rd_idx;
      best_prio  <= rd_prio;
      best_value <= rdata[VALUE_W-1:0];
    end
    if (cmd.walk_start) begin
      ptr <= cmd.walk_from_best ? (CNT_W'(best_idx) + CNT_W'(1)) : '0;
    end else if (rd_issue) begin
      ptr <= ptr + CNT_W'(1);
    end
    if (cmd.report) begin
      rsp.status           <= cmd.code;
      rsp.removed_value    <= (cmd.code == ST_REMOVED) ? best_value : '0;
      rsp.removed_priority <= (cmd.code == ST_REMOVED) ? best_prio : '0;
      rsp.entry_count      <= COUNT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.walk_start) begin
        rd_valid <= 1'b0;
      end else begin
        rd_valid <= rd_issue;
      end
      if (cmd.report) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/mpq_ctrl.sv
// Controller of the max priority queue: sequences accept, insert, scan, compaction
// and report. Depends on mpq_pkg.
module mpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  mpq_pkg::dp_flags_t flags,
  output mpq_pkg::dp_cmd_t   cmd
);
  import mpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_REPORT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = rst || (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (flags.op == OP_REMOVE) begin
          if (!flags.empty) begin
            cmd.walk_start = 1'b1;
            state_next     = S_SCAN;
          end else if (flags.rsp_free) begin
            cmd.report = 1'b1;
            cmd.code   = ST_EMPTY;
            state_next = S_IDLE;
          end
        end else if (flags.rsp_free) begin
          cmd.report = 1'b1;
          if (flags.full) begin
            cmd.code = ST_FULL;
          end else begin
            cmd.insert = 1'b1;
            cmd.code   = ST_INSERTED;
          end
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (flags.walk_done) begin
          cmd.walk_start     = 1'b1;
          cmd.walk_from_best = 1'b1;
          state_next         = S_SHIFT;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        if (flags.walk_done) begin
          state_next = S_REPORT;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_REPORT: begin
        if (flags.rsp_free) begin
          cmd.pop    = 1'b1;
          cmd.report = 1'b1;
          cmd.code   = ST_REMOVED;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/max_priority_queue_top.sv
// Max priority queue: a bounded store of value and priority pairs, served by
// largest signed priority, oldest first among equal priorities.
//
// Channels: the req channel carries one operation (insert or remove) per transfer;
// the rsp channel returns exactly one result per request, carrying the status, the
// removed pair (zero unless something was removed) and the count after the operation.
// Both use valid and stall; a transfer happens on a clock edge with valid high, stall low.
//
// One request is handled at a time. An insert, or a request that reports empty or full,
// is handled in the exec state, which writes the result register and returns to idle
// together, so the result shows and the input is freed at once. A remove walks the store
// through the single read port of the entry memory: the scan state reads each stored
// entry to find the maximum, the shift state moves each entry behind the winner down to
// close the gap, and the report state writes the result and the count.
//
// The result sits in an output register, so a new request is taken while an old result
// is still stalled; the new result waits until that register is free. Reset empties the
// queue and drops any pending result, with req_stall held high throughout; entries above
// the count are never read, so the memory needs no clearing pass.
module max_priority_queue_top #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mpq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mpq_pkg::rsp_t rsp
);
  import mpq_pkg::*;

  // Command and status between the controller and the datapath.
  dp_cmd_t   cmd;
  dp_flags_t flags;

  // The controller owns the request handshake and the sequence of each operation.
  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  // The datapath holds the entries, the occupancy and the result register.
  mpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .flags     (flags),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

>>> sv/mpq_checker.sv
// Port-level checks for the max priority queue, attached to the top level by bind.
// Depends on mpq_pkg and max_priority_queue_top.
module mpq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input mpq_pkg::rsp_t rsp
);
  import mpq_pkg::*;

  // A stalled result stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in work");

  // Nothing removed means zero pair fields.
  a_zero_pair: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_REMOVED) |->
      (rsp.removed_value == '0) && (rsp.removed_priority == '0))
    else $error("pair fields not zero without a removal");

  // An empty report leaves nothing stored.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0))
    else $error("empty reported with entries stored");

endmodule

bind max_priority_queue_top mpq_checker u_mpq_checker (.*);

>>> bench/tb_top.sv
// Self-checking bench for max_priority_queue_top: a directed table, then random
// fill, drain and mixed episodes under varying back-pressure, checked by a scoreboard.
// Depends on mpq_pkg and the max_priority_queue_top RTL only.
module tb_top;
  import mpq_pkg::*;

  localparam int DEPTH           = 64;
  localparam int ITEMS_PER_PHASE = 560;
  localparam int CYCLE_LIMIT     = 1_000_000;
  // Worst case of a remove on a full queue, with margin, used for the final quiet period.
  localparam int SETTLE_CYCLES   = 2 * DEPTH + 16;

  localparam logic signed [PRIO_W-1:0] PRIO_MAX = 32'sh7fff_ffff;
  localparam logic signed [PRIO_W-1:0] PRIO_MIN = 32'sh8000_0000;

  // One row of the directed table. Where typed is set, want holds the result
  // read straight off the behaviour; otherwise the queue model supplies it.
  typedef struct packed {
    req_t item;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  localparam int PLAN_LEN = 23;

  plan_row_t plan [PLAN_LEN] = '{
    // Removes on an empty queue, with the ignored fields both quiet and busy.
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 7'd0}},
    '{'{OP_REMOVE, -32'sd1, PRIO_MAX}, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 7'd0}},
    // A single entry at the extremes goes in and comes straight out again.
    '{'{OP_INSERT, PRIO_MAX, PRIO_MIN}, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 7'd1}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_REMOVED, PRIO_MAX, PRIO_MIN, 7'd0}},
    // Signed ordering: the most positive priority first, then zero, then the most negative.
    '{'{OP_INSERT, PRIO_MIN, PRIO_MAX}, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 7'd1}},
    '{'{OP_INSERT, 32'sd1, PRIO_MIN}, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 7'd2}},
    '{'{OP_INSERT, 32'sd2, 32'sd0}, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 7'd3}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_REMOVED, PRIO_MIN, PRIO_MAX, 7'd2}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_REMOVED, 32'sd2, 32'sd0, 7'd1}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_REMOVED, 32'sd1, PRIO_MIN, 7'd0}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 7'd0}},
    // Equal priorities leave in the order they arrived, even across a later insert.
    '{'{OP_INSERT, 32'sd10, 32'sd5}, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 7'd1}},
    '{'{OP_INSERT, 32'sd11, 32'sd5}, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 7'd2}},
    '{'{OP_INSERT, 32'sd12, -32'sd1}, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 7'd3}},
    '{'{OP_INSERT, 32'sd13, 32'sd5}, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 7'd4}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_REMOVED, 32'sd10, 32'sd5, 7'd3}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_REMOVED, 32'sd11, 32'sd5, 7'd2}},
    '{'{OP_INSERT, 32'sd14, 32'sd5}, 1'b1, '{ST_INSERTED, 32'sd0, 32'sd0, 7'd3}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_REMOVED, 32'sd13, 32'sd5, 7'd2}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_REMOVED, 32'sd14, 32'sd5, 7'd1}},
    '{'{OP_REMOVE, 32'sd0, 32'sd0}, 1'b1, '{ST_REMOVED, 32'sd12, -32'sd1, 7'd0}},
    // Alternating bit patterns, left to the queue model.
    '{'{OP_INSERT, 32'sh5555_5555, 32'shaaaa_aaaa}, 1'b0, '0},
    '{'{OP_REMOVE, 32'shaaaa_aaaa, 32'sh5555_5555}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Queue model: the pairs held, in arrival order, and how many there are.
  logic signed [VALUE_W-1:0] held_value [DEPTH];
  logic signed [PRIO_W-1:0]  held_prio  [DEPTH];
  int held = 0;

  // Results still owed by the block, oldest first.
  rsp_t pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;
  int mismatches    = 0;
  int sent          = 0;
  int checked       = 0;
  int seen_removed  = 0;
  int seen_empty    = 0;
  int seen_full     = 0;

  max_priority_queue_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is bounded by a cycle count, so a hung handshake ends as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Every mismatch passes through here: one line each, and the count goes up.
  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Works out the result of one request and moves the queue model on. The winner is the
  // first entry with the largest signed priority; those behind it close the gap.
  function automatic rsp_t predict_queue_result(input req_t r);
    rsp_t res;
    int   best;
    res = '0;
    if (r.operation == OP_INSERT) begin
      if (held == DEPTH) begin
        res.status = ST_FULL;
      end else begin
        held_value[held] = r.item_value;
        held_prio[held]  = r.item_priority;
        held++;
        res.status = ST_INSERTED;
      end
    end else if (held == 0) begin
      res.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held; i++)
        if (held_prio[i] > held_prio[best]) best = i;
      res.removed_value    = held_value[best];
      res.removed_priority = held_prio[best];
      for (int i = best; i < held - 1; i++) begin
        held_value[i] = held_value[i + 1];
        held_prio[i]  = held_prio[i + 1];
      end
      held--;
      res.status = ST_REMOVED;
    end
    res.entry_count = COUNT_W'(held);
    return res;
  endfunction

  // Compares one accepted result with the oldest expectation, field by field.
  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: %p", got));
    end else begin
      want = pending_results.pop_front();
      checked++;
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, expected %0d", checked,
                                  got.status, want.status));
      if (got.removed_value !== want.removed_value)
        report_mismatch($sformatf("result %0d removed_value %0d, expected %0d", checked,
                                  got.removed_value, want.removed_value));
      if (got.removed_priority !== want.removed_priority)
        report_mismatch($sformatf("result %0d removed_priority %0d, expected %0d", checked,
                                  got.removed_priority, want.removed_priority));
      if (got.entry_count !== want.entry_count)
        report_mismatch($sformatf("result %0d entry_count %0d, expected %0d", checked,
                                  got.entry_count, want.entry_count));
      case (want.status)
        ST_REMOVED: seen_removed++;
        ST_EMPTY:   seen_empty++;
        ST_FULL:    seen_full++;
        default: ;
      endcase
    end
  endtask

  // Result side. A transfer is taken at an edge where valid was high and stall low;
  // both are read as they stood before the edge, and the stall for the next cycle is
  // drawn afterwards with a nonblocking assignment.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid === 1'b1 && !rsp_stall) check_result(rsp);
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Offers one request, with a random idle gap in front of it, and holds it until the
  // transfer. The expectation is queued at the edge of the transfer. Valid is left high
  // on return so that back-to-back requests keep it up without a glitch.
  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = predict_queue_result(r);
    pending_results.push_back(typed ? want : predicted);
    sent++;
  endtask

  // Stops offering requests until the block has returned everything it owes.
  task automatic hold_until_settled();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random request. Priorities mostly come from a narrow band so that ties are common,
  // with full-range and extreme values mixed in. Removes carry random fields as well,
  // since the block must ignore them.
  function automatic req_t random_request(input bit remove);
    req_t r;
    r.operation  = remove ? OP_REMOVE : OP_INSERT;
    r.item_value = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: r.item_priority = $signed($urandom_range(0, 6)) - 3;
      5, 6, 7:       r.item_priority = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       r.item_priority = PRIO_MIN;
          1:       r.item_priority = PRIO_MAX;
          2:       r.item_priority = -32'sd1;
          default: r.item_priority = 32'sd0;
        endcase
      end
    endcase
    return r;
  endfunction

  initial begin
    int phase_start;
    int pick;

    // Reset is held from the start and then released for good.
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 65;
    foreach (plan[i]) send_request(plan[i].item, plan[i].typed, plan[i].want);

    // Three phases of back-pressure: a slow receiver, then a slow sender, then neither.
    // Each phase is made of episodes: mixed traffic, filling to the brim and pushing on
    // into full, or draining to nothing and pulling on into empty.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = sent;
      while (sent - phase_start < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          repeat ($urandom_range(4, 40))
            send_request(random_request($urandom_range(0, 99) < 45), 1'b0, '0);
        end else if (pick < 8) begin
          while (held < DEPTH) send_request(random_request(1'b0), 1'b0, '0);
          repeat ($urandom_range(1, 3)) send_request(random_request(1'b0), 1'b0, '0);
        end else begin
          while (held > 0) send_request(random_request(1'b1), 1'b0, '0);
          repeat ($urandom_range(1, 3)) send_request(random_request(1'b1), 1'b0, '0);
        end
        // Now and then the sender waits for the block to go quiet before carrying on.
        if ($urandom_range(0, 7) == 0) hold_until_settled();
      end
      hold_until_settled();
    end

    // Any stray result after the last expected one would be caught in this window.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d requests, checked %0d results: %0d removals, %0d empty, %0d full",
             sent, checked, seen_removed, seen_empty, seen_full);
    $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/mpq_pkg.sv
sv/mpq_datapath.sv
sv/mpq_ctrl.sv
sv/max_priority_queue_top.sv
sv/mpq_checker.sv
bench/tb_top.sv
